[hdl/pwhr_pkg.sv]
// Package of constants, types and the axis mapping for the pulse width to report block.
`default_nettype none

package pwhr_pkg;

	// Pulse width window that maps onto the axis byte, in microseconds.
	localparam logic [15:0] AXIS_LOW         = 16'd732;
	localparam logic [15:0] AXIS_HIGH        = 16'd2267;
	localparam logic [15:0] AXIS_STEP        = 16'd6;
	localparam logic [15:0] BUTTON_THRESHOLD = 16'd1500;

	// Width of the clamped offset and the reciprocal of the step, scaled by 2^18.
	localparam int          AXIS_OFS_W  = 11;
	localparam int          RECIP_SHIFT = 18;
	localparam int          PROD_W      = AXIS_OFS_W + 16;
	localparam logic [15:0] AXIS_RECIP  = 16'(((1 << RECIP_SHIFT) + 16'd5) / 6);

	localparam int NUM_AXES   = 4;
	localparam int REPORT_MAX = 6;

	localparam logic [7:0] REPORT_ID_A = 8'd1;
	localparam logic [7:0] REPORT_ID_B = 8'd2;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_A    = 3'd5;
	localparam logic [2:0] LEN_B    = 3'd6;

	typedef logic [2:0]  byte_idx_t;
	typedef logic [7:0]  report_byte_t;
	typedef logic [15:0] pulse_t;

	// Clamps a pulse width to the window and divides its offset by six.
	// The offset is below 1536, so the scaled reciprocal gives the exact quotient.
	function automatic report_byte_t axis_byte(input pulse_t w);
		logic [AXIS_OFS_W-1:0] ofs;
		logic [PROD_W-1:0]     prod;
		if (w < AXIS_LOW) begin
			ofs = '0;
		end else if (w > AXIS_HIGH) begin
			ofs = AXIS_OFS_W'(AXIS_HIGH - AXIS_LOW);
		end else begin
			ofs = AXIS_OFS_W'(w - AXIS_LOW);
		end
		prod = PROD_W'(ofs) * PROD_W'(AXIS_RECIP);
		return prod[RECIP_SHIFT +: 8];
	endfunction

endpackage

`default_nettype wire

[hdl/pulse_width_to_hid_report_top.sv]
// Top level: turns a pulse width snapshot into a joystick report emitted byte by byte.
`default_nettype none

// Each accepted transaction carries a report id and eight pulse widths. The id is
// resolved and registered on acceptance (zero rotates between reports 1 and 2), the
// report is built in one pass and loaded into a six byte buffer, and the buffer is
// sent out one byte per cycle while out_stall is low. Report 1 has 5 bytes, report 2
// has 6, and an unknown id produces no bytes and leaves the input stage in the first
// cycle in which the report buffer is free. The output byte serialiser sets the rate:
// the input register takes the next transaction while the current report is still
// being sent and hands it over in the cycle of the last byte.
module pulse_width_to_hid_report_top
	import pwhr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   request_id,
	input  wire logic [15:0]  channel_0,
	input  wire logic [15:0]  channel_1,
	input  wire logic [15:0]  channel_2,
	input  wire logic [15:0]  channel_3,
	input  wire logic [15:0]  channel_4,
	input  wire logic [15:0]  channel_5,
	input  wire logic [15:0]  channel_6,
	input  wire logic [15:0]  channel_7,

	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        report_byte,
	output logic              last_byte
);

	logic         cur_id_lsb;
	logic [7:0]   cur_id_val_q;
	logic [7:0]   next_id;
	logic         in_accept;

	logic         valid_s1;
	logic [7:0]   id_s1;
	pulse_t       chan_s1 [8];

	logic         valid_s2;
	report_byte_t buf_s2 [REPORT_MAX];
	byte_idx_t    len_s2;
	byte_idx_t    idx_q;

	logic         out_done;
	logic         s2_free;
	logic         s1_move;
	byte_idx_t    len_new;
	report_byte_t bytes_new [REPORT_MAX];
	report_byte_t buttons;
	logic         pick_b;

	// Only the low bit of the stored id matters to the rotation rule: an even id
	// leads to report 1 and an odd id to report 2.
	assign cur_id_lsb = cur_id_val_q[0];
	assign next_id    = (request_id != 8'd0) ? request_id : {7'd0, cur_id_lsb} + 8'd1;

	assign out_valid   = valid_s2;
	assign report_byte = buf_s2[idx_q];
	assign last_byte   = (idx_q == len_s2 - 3'd1);
	assign out_done    = valid_s2 && !out_stall && last_byte;
	assign s2_free     = !valid_s2 || out_done;
	assign s1_move     = valid_s1 && s2_free;
	assign in_stall    = valid_s1 && !s2_free;
	assign in_accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_id_val_q <= 8'd0;
		end else if (in_accept) begin
			cur_id_val_q <= next_id;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			id_s1      <= next_id;
			chan_s1[0] <= channel_0;
			chan_s1[1] <= channel_1;
			chan_s1[2] <= channel_2;
			chan_s1[3] <= channel_3;
			chan_s1[4] <= channel_4;
			chan_s1[5] <= channel_5;
			chan_s1[6] <= channel_6;
			chan_s1[7] <= channel_7;
		end
	end

	// Report assembly: the axis channels are chosen first so that only four
	// clamp and divide units are needed.
	always_comb begin
		pick_b  = (id_s1 == REPORT_ID_B);
		buttons = '0;
		for (int i = 0; i < 8; i++) begin
			buttons[i] = (chan_s1[i] > BUTTON_THRESHOLD);
		end
		bytes_new[0] = id_s1;
		for (int i = 0; i < NUM_AXES; i++) begin
			bytes_new[i + 1] = axis_byte(pick_b ? chan_s1[i + NUM_AXES] : chan_s1[i]);
		end
		bytes_new[REPORT_MAX - 1] = buttons;
		if (id_s1 == REPORT_ID_A) begin
			len_new = LEN_A;
		end else if (pick_b) begin
			len_new = LEN_B;
		end else begin
			len_new = LEN_NONE;
		end
	end

	// Report buffer and byte serialiser.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
			len_s2   <= LEN_NONE;
		end else if (s2_free) begin
			valid_s2 <= s1_move && (len_new != LEN_NONE);
			idx_q    <= '0;
			len_s2   <= len_new;
		end else if (!out_stall) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && s2_free) begin
			for (int i = 0; i < REPORT_MAX; i++) begin
				buf_s2[i] <= bytes_new[i];
			end
		end
	end

endmodule

`default_nettype wire

[verif/tb_pulse_width_to_hid_report_top.sv]
// Self-checking testbench for the pulse width to joystick report block.

module tb_pulse_width_to_hid_report_top;
	import pwhr_pkg::*;

	typedef pulse_t [7:0] pulse_set_t;

	typedef struct packed {
		report_byte_t data;
		logic         last;
	} report_beat_t;

	localparam int IDLE_LIMIT     = 3000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int RANDOM_REPORTS = 220;

	logic         clk        = 1'b0;
	logic         arst_n     = 1'b0;
	logic         in_valid   = 1'b0;
	logic         in_stall;
	logic [7:0]   request_id = '0;
	pulse_t       channel_0  = '0;
	pulse_t       channel_1  = '0;
	pulse_t       channel_2  = '0;
	pulse_t       channel_3  = '0;
	pulse_t       channel_4  = '0;
	pulse_t       channel_5  = '0;
	pulse_t       channel_6  = '0;
	pulse_t       channel_7  = '0;
	logic         out_valid;
	logic         out_stall  = 1'b0;
	report_byte_t report_byte;
	logic         last_byte;

	logic [7:0]   active_id = '0;
	report_beat_t pending_bytes[$];
	int           mismatch_count = 0;
	int           idle_cycles = 0;
	int           stall_run = 0;
	bit           calm = 1'b0;

	pulse_width_to_hid_report_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.request_id  (request_id),
		.channel_0   (channel_0),
		.channel_1   (channel_1),
		.channel_2   (channel_2),
		.channel_3   (channel_3),
		.channel_4   (channel_4),
		.channel_5   (channel_5),
		.channel_6   (channel_6),
		.channel_7   (channel_7),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.report_byte (report_byte),
		.last_byte   (last_byte)
	);

	always #1 clk = ~clk;

	// Mostly short gaps, now and then a long one; none at all in a calm stretch.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic report_byte_t scale_width(input pulse_t w);
		int unsigned v;
		v = w;
		if (v < AXIS_LOW) v = AXIS_LOW;
		if (v > AXIS_HIGH) v = AXIS_HIGH;
		return report_byte_t'((v - AXIS_LOW) / AXIS_STEP);
	endfunction

	// Resolves the report id and queues the bytes that the report should carry.
	function automatic void predict_report(input logic [7:0] req, input pulse_set_t ch);
		report_byte_t buttons;
		buttons = '0;
		if (req != 8'd0) begin
			active_id = req;
		end else begin
			active_id = 8'((active_id % 8'd2) + 8'd1);
		end
		if (active_id == REPORT_ID_A) begin
			pending_bytes.push_back({active_id, 1'b0});
			for (int i = 0; i < NUM_AXES; i++)
				pending_bytes.push_back({scale_width(ch[i]), i == NUM_AXES - 1});
		end else if (active_id == REPORT_ID_B) begin
			pending_bytes.push_back({active_id, 1'b0});
			for (int i = 0; i < NUM_AXES; i++)
				pending_bytes.push_back({scale_width(ch[NUM_AXES + i]), 1'b0});
			for (int i = 0; i < 8; i++)
				buttons[i] = ch[i] > BUTTON_THRESHOLD;
			pending_bytes.push_back({buttons, 1'b1});
		end
	endfunction

	function automatic pulse_set_t snap(input pulse_t c0, input pulse_t c1, input pulse_t c2,
			input pulse_t c3, input pulse_t c4, input pulse_t c5, input pulse_t c6,
			input pulse_t c7);
		return {c7, c6, c5, c4, c3, c2, c1, c0};
	endfunction

	function automatic pulse_t random_width();
		case ($urandom_range(0, 9))
			0, 1: return pulse_t'($urandom);
			2: begin
				case ($urandom_range(0, 7))
					0: return 16'd0;
					1: return 16'd731;
					2: return 16'd732;
					3: return 16'd2267;
					4: return 16'd2268;
					5: return 16'd1500;
					6: return 16'd1501;
					default: return 16'hFFFF;
				endcase
			end
			default: return pulse_t'($urandom_range(700, 2300));
		endcase
	endfunction

	function automatic pulse_set_t random_snapshot();
		pulse_set_t s;
		for (int i = 0; i < 8; i++)
			s[i] = random_width();
		return s;
	endfunction

	function automatic logic [7:0] random_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 8'd0;
		if (r < 65) return REPORT_ID_A;
		if (r < 90) return REPORT_ID_B;
		return 8'($urandom);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Presents one request and holds it until the block takes the transaction.
	task automatic send_request(input logic [7:0] req, input pulse_set_t ch);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		request_id <= req;
		channel_0  <= ch[0];
		channel_1  <= ch[1];
		channel_2  <= ch[2];
		channel_3  <= ch[3];
		channel_4  <= ch[4];
		channel_5  <= ch[5];
		channel_6  <= ch[6];
		channel_7  <= ch[7];
		do @(posedge clk); while (in_stall);
		predict_report(req, ch);
	endtask

	always @(negedge clk) begin
		if (!arst_n || calm) begin
			out_stall <= 1'b0;
		end else if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run = stall_run - 1;
		end else if ($urandom_range(0, 99) < 30) begin
			out_stall <= 1'b1;
			stall_run = pick_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		report_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("byte %02h arrived with none outstanding", report_byte));
			end else begin
				want = pending_bytes.pop_front();
				if (report_byte !== want.data)
					report_mismatch($sformatf("report_byte %02h, wanted %02h",
						report_byte, want.data));
				if (last_byte !== want.last)
					report_mismatch($sformatf("last_byte %b, wanted %b", last_byte, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Zero ids rotate; unknown ids are silent yet still steer the next rotation.
	task automatic test_rotation();
		send_request(8'd0, {8{16'd1200}});
		send_request(8'd0, random_snapshot());
		send_request(8'd0, random_snapshot());
		send_request(8'd3, random_snapshot());
		send_request(8'd0, random_snapshot());
		send_request(8'd255, random_snapshot());
		send_request(8'd0, random_snapshot());
		send_request(8'd4, random_snapshot());
		send_request(8'd0, random_snapshot());
		send_request(8'd128, random_snapshot());
		send_request(8'd0, random_snapshot());
	endtask

	task automatic test_axis_limits();
		send_request(REPORT_ID_A, snap(16'd0, 16'd731, 16'd732, 16'd733, 0, 0, 0, 0));
		send_request(REPORT_ID_A, snap(16'd737, 16'd738, 16'd2267, 16'd2268, 0, 0, 0, 0));
		send_request(REPORT_ID_A, {8{16'hFFFF}});
		send_request(REPORT_ID_B, snap(16'hFFFF, 16'd2268, 16'd2267, 16'd1000,
			16'd0, 16'd731, 16'd732, 16'd738));
		send_request(REPORT_ID_B, {8{16'd0}});
	endtask

	task automatic test_button_threshold();
		send_request(REPORT_ID_B, snap(16'd1500, 16'd1501, 16'd1500, 16'd1501,
			16'd1500, 16'd1501, 16'd1500, 16'd1501));
		send_request(REPORT_ID_B, snap(16'd1501, 16'd1500, 16'd1501, 16'd1500,
			16'd1501, 16'd1500, 16'd1501, 16'd1500));
		send_request(REPORT_ID_B, {8{16'hAAAA}});
		send_request(REPORT_ID_B, {8{16'h5555}});
	endtask

	task automatic test_random_reports();
		for (int n = 0; n < RANDOM_REPORTS; n++) begin
			calm = (n >= 90 && n < 130);
			send_request(random_id(), random_snapshot());
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_rotation();
		test_axis_limits();
		test_button_threshold();
		test_random_reports();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
